// ===== sv/ffea_pkg.sv =====
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared types and constants of the first-fit extent sector allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

    localparam int MAX_EXTENTS = 4096;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

    localparam int REQ_W    = 2;
    localparam int ID_W     = 30;
    localparam int COUNT_W  = 16;
    localparam int SECTOR_W = 30;
    localparam int OWNER_W  = 31;
    localparam int LAST_W   = 31;

    localparam logic [OWNER_W-1:0] FREE_OWNER = {OWNER_W{1'b1}};
    localparam logic [LAST_W-1:0]  UNBOUNDED  = {LAST_W{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef struct packed {
        logic [OWNER_W-1:0]  owner;
        logic [SECTOR_W-1:0] first;
        logic [LAST_W-1:0]   last;
        logic [IDX_W-1:0]    link;
    } t_extent;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_extent          data;
    } t_mem_wr;

    typedef struct packed {
        logic               valid;
        logic [OWNER_W-1:0] owner;
        logic               status;
    } t_result;

endpackage

// ===== sv/ffea_mem.sv =====
// ----------------------------------------------------------------------------
// ffea_mem
// Extent table: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffea_mem
    import ffea_pkg::*;
(
    input  logic             i_clk,
    input  t_mem_wr          i_wr,
    input  logic [IDX_W-1:0] i_raddr,
    output t_extent          o_rdata
);

    t_extent r_mem [MAX_EXTENTS];
    t_extent r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ffea_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffea_ctrl
// Request sequencer that walks the linked extent table one entry per cycle,
// modifies entries in place and splits free extents on a write.
// ----------------------------------------------------------------------------
module ffea_ctrl
    import ffea_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [ID_W-1:0]     i_file_id,
    input  logic [COUNT_W-1:0]  i_sector_count,
    input  logic [SECTOR_W-1:0] i_sector_index,
    output t_result             o_res,
    input  logic                i_res_take,
    output logic [IDX_W-1:0]    o_mem_raddr,
    input  t_extent             i_mem_rdata,
    output t_mem_wr             o_mem_wr
);

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_SPLIT = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    t_req                r_req, n_req;
    logic [ID_W-1:0]     r_id, n_id;
    logic [COUNT_W-1:0]  r_need, n_need;
    logic [SECTOR_W-1:0] r_sector, n_sector;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_steps, n_steps;
    logic [CNT_W-1:0]    r_used, n_used;
    logic [OWNER_W-1:0]  r_owner, n_owner;
    logic                r_status, n_status;
    logic [IDX_W-1:0]    r_split_n, n_split_n;
    t_extent             r_split_rec, n_split_rec;

    logic                accept;
    logic [CNT_W-1:0]    steps_inc;
    logic                more_steps;
    logic                is_free;
    logic                unbounded;
    logic                last_lt_first;
    logic [LAST_W-1:0]   span;
    logic                fits_all;
    logic [COUNT_W-1:0]  need_after;
    logic [SECTOR_W-1:0] split_first;
    logic [SECTOR_W-1:0] split_last;
    logic                read_hit;
    logic                del_hit;
    t_extent             head_rec;

    assign accept        = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall    = (r_state != ST_IDLE);
    assign steps_inc     = r_steps + CNT_W'(1);
    assign more_steps    = (steps_inc < r_used);
    assign is_free       = (i_mem_rdata.owner == FREE_OWNER);
    assign unbounded     = (i_mem_rdata.last == UNBOUNDED);
    assign last_lt_first = (i_mem_rdata.last < {1'b0, i_mem_rdata.first});
    assign span          = i_mem_rdata.last - {1'b0, i_mem_rdata.first};
    assign fits_all      = !unbounded &&
                           (last_lt_first || (span < LAST_W'(r_need)));
    assign need_after    = last_lt_first ? r_need
                                         : (r_need - span[COUNT_W-1:0] - COUNT_W'(1));
    assign split_first   = i_mem_rdata.first + SECTOR_W'(r_need);
    assign split_last    = split_first - SECTOR_W'(1);
    assign read_hit      = (r_sector >= i_mem_rdata.first) &&
                           (unbounded || ({1'b0, r_sector} <= i_mem_rdata.last));
    assign del_hit       = (i_mem_rdata.owner == {1'b0, r_id});

    assign head_rec.owner = FREE_OWNER;
    assign head_rec.first = '0;
    assign head_rec.last  = UNBOUNDED;
    assign head_rec.link  = '0;

    assign o_mem_raddr = (r_state == ST_WALK) ? i_mem_rdata.link : '0;

    assign o_res.valid  = (r_state == ST_DONE);
    assign o_res.owner  = r_owner;
    assign o_res.status = r_status;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_id        = r_id;
        n_need      = r_need;
        n_sector    = r_sector;
        n_idx       = r_idx;
        n_steps     = r_steps;
        n_used      = r_used;
        n_owner     = r_owner;
        n_status    = r_status;
        n_split_n   = r_split_n;
        n_split_rec = r_split_rec;
        o_mem_wr    = '0;

        unique case (r_state)
            ST_INIT: begin
                o_mem_wr.en   = 1'b1;
                o_mem_wr.addr = '0;
                o_mem_wr.data = head_rec;
                n_used        = CNT_W'(1);
                n_state       = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_req    = t_req'(i_req_type);
                    n_id     = i_file_id;
                    n_need   = i_sector_count;
                    n_sector = i_sector_index;
                    n_idx    = '0;
                    n_steps  = '0;
                    n_owner  = '0;
                    n_status = 1'b0;
                    if (t_req'(i_req_type) == REQ_CLEAR) begin
                        o_mem_wr.en   = 1'b1;
                        o_mem_wr.addr = '0;
                        o_mem_wr.data = head_rec;
                        n_used        = CNT_W'(1);
                        n_state       = ST_DONE;
                    end else if (t_req'(i_req_type) == REQ_WRITE &&
                                 i_sector_count == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                n_steps = steps_inc;
                n_idx   = i_mem_rdata.link;
                if (!more_steps) begin
                    n_state = ST_DONE;
                end
                case (r_req)
                    REQ_WRITE: begin
                        if (is_free) begin
                            if (fits_all) begin
                                o_mem_wr.en          = 1'b1;
                                o_mem_wr.addr        = r_idx;
                                o_mem_wr.data        = i_mem_rdata;
                                o_mem_wr.data.owner  = {1'b0, r_id};
                                n_need               = need_after;
                                if (need_after == '0) begin
                                    n_state = ST_DONE;
                                end
                            end else if (r_used >= CNT_W'(MAX_EXTENTS)) begin
                                n_status = 1'b1;
                                n_state  = ST_DONE;
                            end else begin
                                o_mem_wr.en         = 1'b1;
                                o_mem_wr.addr       = r_idx;
                                o_mem_wr.data.owner = {1'b0, r_id};
                                o_mem_wr.data.first = i_mem_rdata.first;
                                o_mem_wr.data.last  = {1'b0, split_last};
                                o_mem_wr.data.link  = r_used[IDX_W-1:0];
                                n_split_n           = r_used[IDX_W-1:0];
                                n_split_rec.owner   = FREE_OWNER;
                                n_split_rec.first   = split_first;
                                n_split_rec.last    = i_mem_rdata.last;
                                n_split_rec.link    = i_mem_rdata.link;
                                n_used              = r_used + CNT_W'(1);
                                n_state             = ST_SPLIT;
                            end
                        end
                    end
                    REQ_READ: begin
                        if (read_hit) begin
                            n_owner = i_mem_rdata.owner;
                            n_state = ST_DONE;
                        end else if (!more_steps) begin
                            n_owner = FREE_OWNER;
                        end
                    end
                    REQ_DELETE: begin
                        if (del_hit) begin
                            o_mem_wr.en         = 1'b1;
                            o_mem_wr.addr       = r_idx;
                            o_mem_wr.data       = i_mem_rdata;
                            o_mem_wr.data.owner = FREE_OWNER;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_SPLIT: begin
                o_mem_wr.en   = 1'b1;
                o_mem_wr.addr = r_split_n;
                o_mem_wr.data = r_split_rec;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_used  <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_id        <= n_id;
        r_need      <= n_need;
        r_sector    <= n_sector;
        r_idx       <= n_idx;
        r_steps     <= n_steps;
        r_owner     <= n_owner;
        r_status    <= n_status;
        r_split_n   <= n_split_n;
        r_split_rec <= n_split_rec;
    end

    a_split_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SPLIT) |=> (r_state == ST_DONE))
        else $error("Split did not finish the transaction.");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_steps < r_used))
        else $error("Walk went past the number of linked extents.");

    a_split_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SPLIT) |-> (r_used == $past(r_used) + CNT_W'(1)))
        else $error("Split did not allocate a new extent.");

    a_split_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SPLIT) |-> (r_split_n == IDX_W'(r_used - CNT_W'(1))))
        else $error("Split writes outside the newest extent slot.");

endmodule

// ===== sv/first_fit_extent_sector_allocator.sv =====
// A transaction enters in the idle state; the walk state visits extents along the
// links (up to the number of linked extents), a split adds the split state, and the
// done state hands the result to the output register. A clear or a zero-sector
// write goes from idle to done. No transaction enters until the result is taken.
// After reset the init state writes the head extent before the first transaction.
// ----------------------------------------------------------------------------
// first_fit_extent_sector_allocator
// Top level: extent table memory, walk sequencer and output register.
// ----------------------------------------------------------------------------
module first_fit_extent_sector_allocator
    import ffea_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [REQ_W-1:0]           i_req_type,
    input  logic [ID_W-1:0]            i_file_id,
    input  logic [COUNT_W-1:0]         i_sector_count,
    input  logic [SECTOR_W-1:0]        i_sector_index,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [OWNER_W-1:0]  o_owner_id,
    output logic                       o_status
);

    t_result            res;
    logic               res_take;
    logic [IDX_W-1:0]   mem_raddr;
    t_extent            mem_rdata;
    t_mem_wr            mem_wr;

    logic               r_out_valid;
    logic [OWNER_W-1:0] r_out_owner;
    logic               r_out_status;

    ffea_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ffea_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_file_id      (i_file_id),
        .i_sector_count (i_sector_count),
        .i_sector_index (i_sector_index),
        .o_res          (res),
        .i_res_take     (res_take),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata),
        .o_mem_wr       (mem_wr)
    );

    assign res_take = res.valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_owner  <= res.owner;
            r_out_status <= res.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_owner_id  = r_out_owner;
    assign o_status    = r_out_status;

endmodule

// ===== tb/sv/tb_first_fit_extent_sector_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_extent_sector_allocator
// A table of directed requests is followed by random write, read, delete and
// clear traffic with random request gaps and result stalls. Each result is
// compared with its row's fixed value or the bench's extent-table predictor.
// ----------------------------------------------------------------------------
module tb_first_fit_extent_sector_allocator;
    import ffea_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic               status;
    } t_alloc_result;

    typedef struct {
        t_req                req;
        logic [ID_W-1:0]     file_id;
        logic [COUNT_W-1:0]  count;
        logic [SECTOR_W-1:0] sector;
        bit                  has_fixed;
        logic [OWNER_W-1:0]  fixed_owner;
        logic                fixed_status;
    } t_stim_row;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_stall;
    logic [REQ_W-1:0]          i_req_type     = '0;
    logic [ID_W-1:0]           i_file_id      = '0;
    logic [COUNT_W-1:0]        i_sector_count = '0;
    logic [SECTOR_W-1:0]       i_sector_index = '0;
    logic                      o_out_valid;
    logic                      i_out_stall    = 1'b0;
    logic signed [OWNER_W-1:0] o_owner_id;
    logic                      o_status;

    bit                 typed_valid  = 1'b0;
    logic [OWNER_W-1:0] typed_owner  = '0;
    logic               typed_status = 1'b0;

    logic [OWNER_W-1:0]  ext_owner [MAX_EXTENTS];
    logic [SECTOR_W-1:0] ext_first [MAX_EXTENTS];
    logic [LAST_W-1:0]   ext_last  [MAX_EXTENTS];
    logic [IDX_W-1:0]    ext_link  [MAX_EXTENTS];
    int                  ext_used;

    t_alloc_result   owner_status_q [$];
    t_stim_row       directed_rows  [$];
    logic [ID_W-1:0] id_pool        [8];

    int          mismatch_count = 0;
    int          result_count   = 0;
    int          req_seen [4]   = '{0, 0, 0, 0};
    int          peak_extents   = 1;
    int          full_count     = 0;
    int          cycle_count    = 0;
    int unsigned no_gap_left    = 0;

    first_fit_extent_sector_allocator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_file_id      (i_file_id),
        .i_sector_count (i_sector_count),
        .i_sector_index (i_sector_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_owner_id     (o_owner_id),
        .o_status       (o_status)
    );

    always #1 i_clk = ~i_clk;

    task automatic restore_single_extent();
        ext_owner[0] = FREE_OWNER;
        ext_first[0] = '0;
        ext_last[0]  = UNBOUNDED;
        ext_link[0]  = '0;
        ext_used     = 1;
    endtask

    task automatic predict_owner_status(
        input  t_req                req,
        input  logic [ID_W-1:0]     id,
        input  logic [COUNT_W-1:0]  count,
        input  logic [SECTOR_W-1:0] sector,
        output t_alloc_result       res
    );
        logic [IDX_W-1:0]    cur;
        logic [IDX_W-1:0]    spare;
        logic [SECTOR_W-1:0] piece_last;
        logic [SECTOR_W-1:0] tail_first;
        longint unsigned     need;
        longint unsigned     f;
        longint unsigned     l;
        int                  steps;
        bit                  done;
        res.owner  = '0;
        res.status = 1'b0;
        cur        = '0;
        done       = 1'b0;
        steps      = 0;
        case (req)
            REQ_WRITE: begin
                need = 64'(count);
                while (need != 0 && steps < ext_used && !done) begin
                    steps++;
                    if (ext_owner[cur] == FREE_OWNER) begin
                        f = 64'(ext_first[cur]);
                        l = 64'(ext_last[cur]);
                        if (ext_last[cur] != UNBOUNDED && (l < f || l - f + 1 <= need)) begin
                            ext_owner[cur] = {1'b0, id};
                            if (l >= f) begin
                                need = need - (l - f + 1);
                            end
                        end else if (ext_used >= MAX_EXTENTS) begin
                            res.status = 1'b1;
                            done       = 1'b1;
                        end else begin
                            spare            = IDX_W'(ext_used);
                            piece_last       = SECTOR_W'(f + need - 1);
                            tail_first       = SECTOR_W'(f + need);
                            ext_link[spare]  = ext_link[cur];
                            ext_link[cur]    = spare;
                            ext_owner[cur]   = {1'b0, id};
                            ext_last[cur]    = {1'b0, piece_last};
                            ext_owner[spare] = FREE_OWNER;
                            ext_first[spare] = tail_first;
                            ext_last[spare]  = LAST_W'(l);
                            ext_used++;
                            done = 1'b1;
                        end
                    end
                    if (!done) begin
                        cur = ext_link[cur];
                    end
                end
            end
            REQ_READ: begin
                res.owner = FREE_OWNER;
                for (steps = 0; steps < ext_used && !done; steps++) begin
                    if (sector >= ext_first[cur] &&
                        (ext_last[cur] == UNBOUNDED || {1'b0, sector} <= ext_last[cur])) begin
                        res.owner = ext_owner[cur];
                        done      = 1'b1;
                    end else begin
                        cur = ext_link[cur];
                    end
                end
            end
            REQ_DELETE: begin
                for (steps = 0; steps < ext_used; steps++) begin
                    if (ext_owner[cur] == {1'b0, id}) begin
                        ext_owner[cur] = FREE_OWNER;
                    end
                    cur = ext_link[cur];
                end
            end
            REQ_CLEAR: begin
                restore_single_extent();
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("MISMATCH result %0d: %s, expected %h, got %h",
                     result_count, what, want, got);
        end
    endtask

    task automatic add_row(input t_req req, input logic [ID_W-1:0] file_id,
                           input logic [COUNT_W-1:0] count,
                           input logic [SECTOR_W-1:0] sector, input bit has_fixed,
                           input logic [OWNER_W-1:0] fixed_owner,
                           input logic fixed_status);
        t_stim_row row;
        row.req          = req;
        row.file_id      = file_id;
        row.count        = count;
        row.sector       = sector;
        row.has_fixed    = has_fixed;
        row.fixed_owner  = fixed_owner;
        row.fixed_status = fixed_status;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input t_req req, input logic [ID_W-1:0] file_id,
                                input logic [COUNT_W-1:0] count,
                                input logic [SECTOR_W-1:0] sector, input bit has_fixed,
                                input logic [OWNER_W-1:0] fixed_owner,
                                input logic fixed_status);
        int unsigned gap;
        int unsigned pick;
        gap = 0;
        if (no_gap_left != 0) begin
            no_gap_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                no_gap_left = $urandom_range(20, 50);
            end else if (pick < 55) begin
                gap = 0;
            end else if (pick < 85) begin
                gap = $urandom_range(1, 3);
            end else if (pick < 95) begin
                gap = $urandom_range(4, 8);
            end else begin
                gap = $urandom_range(15, 40);
            end
        end
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_file_id      <= file_id;
        i_sector_count <= count;
        i_sector_index <= sector;
        typed_valid    <= has_fixed;
        typed_owner    <= fixed_owner;
        typed_status   <= fixed_status;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_alloc_result predicted;
        t_alloc_result want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_owner_status(t_req'(i_req_type), i_file_id, i_sector_count,
                                     i_sector_index, predicted);
                if (typed_valid) begin
                    predicted.owner  = typed_owner;
                    predicted.status = typed_status;
                end
                owner_status_q.push_back(predicted);
                req_seen[i_req_type]++;
                if (ext_used > peak_extents) begin
                    peak_extents = ext_used;
                end
                if (predicted.status) begin
                    full_count++;
                end
            end
            if (o_out_valid && !i_out_stall) begin
                result_count++;
                if (owner_status_q.size() == 0) begin
                    report_mismatch("result with no open request", '0,
                                    {1'b0, o_owner_id});
                end else begin
                    want = owner_status_q.pop_front();
                    if (o_owner_id !== want.owner) begin
                        report_mismatch("owner_id", {1'b0, want.owner}, {1'b0, o_owner_id});
                    end
                    if (o_status !== want.status) begin
                        report_mismatch("status", 32'(want.status), 32'(o_status));
                    end
                end
            end
        end
    end

    initial begin : result_backpressure
        int unsigned mode;
        int unsigned stall_len;
        int unsigned free_len;
        forever begin
            mode = $urandom_range(0, 19);
            if (mode < 6) begin
                stall_len = 0;
                free_len  = $urandom_range(20, 80);
            end else if (mode < 18) begin
                stall_len = $urandom_range(1, 3);
                free_len  = $urandom_range(1, 6);
            end else begin
                stall_len = $urandom_range(20, 60);
                free_len  = $urandom_range(1, 6);
            end
            if (stall_len != 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (stall_len - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            repeat (free_len - 1) @(negedge i_clk);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("first_fit_extent_sector_allocator test failed");
        $finish;
    end

    initial begin : stimulus
        int                  n;
        int                  k;
        int unsigned         pick;
        t_req                req;
        logic [ID_W-1:0]     id;
        logic [COUNT_W-1:0]  count;
        logic [SECTOR_W-1:0] sector;
        logic [SECTOR_W-1:0] tail;
        logic [IDX_W-1:0]    cur;
        logic [ID_W-1:0]     id_max;
        logic [SECTOR_W-1:0] sector_max;

        restore_single_extent();
        id_max     = '1;
        sector_max = '1;
        id_pool[0] = 0;
        id_pool[1] = 1;
        id_pool[2] = 2;
        id_pool[3] = 3;
        id_pool[4] = id_max;
        for (k = 5; k < 8; k++) begin
            id_pool[k] = ID_W'($urandom);
        end

        add_row(REQ_READ,   0,       0,     0,          1, FREE_OWNER, 1'b0);
        add_row(REQ_READ,   0,       0,     sector_max, 1, FREE_OWNER, 1'b0);
        add_row(REQ_WRITE,  5,       0,     0,          1, '0, 1'b0);
        add_row(REQ_WRITE,  5,       1,     0,          1, '0, 1'b0);
        add_row(REQ_READ,   0,       0,     0,          1, 31'd5, 1'b0);
        add_row(REQ_READ,   0,       0,     1,          1, FREE_OWNER, 1'b0);
        add_row(REQ_WRITE,  id_max,  '1,    0,          1, '0, 1'b0);
        add_row(REQ_READ,   0,       0,     65535,      1, {1'b0, id_max}, 1'b0);
        add_row(REQ_READ,   0,       0,     65536,      1, FREE_OWNER, 1'b0);
        add_row(REQ_WRITE,  0,       3,     0,          1, '0, 1'b0);
        add_row(REQ_DELETE, 5,       0,     0,          1, '0, 1'b0);
        add_row(REQ_READ,   0,       0,     0,          1, FREE_OWNER, 1'b0);
        add_row(REQ_WRITE,  7,       2,     0,          1, '0, 1'b0);
        add_row(REQ_READ,   0,       0,     0,          0, '0, 1'b0);
        add_row(REQ_READ,   0,       0,     65539,      0, '0, 1'b0);
        add_row(REQ_READ,   0,       0,     65538,      0, '0, 1'b0);
        add_row(REQ_DELETE, 0,       0,     0,          1, '0, 1'b0);
        add_row(REQ_DELETE, 12345,   0,     0,          1, '0, 1'b0);
        add_row(REQ_READ,   0,       0,     65537,      0, '0, 1'b0);
        add_row(REQ_WRITE,  9,       4,     0,          1, '0, 1'b0);
        add_row(REQ_READ,   0,       0,     65540,      0, '0, 1'b0);
        add_row(REQ_READ,   0,       0,     sector_max, 0, '0, 1'b0);
        add_row(REQ_CLEAR,  id_max,  '1,    sector_max, 1, '0, 1'b0);
        add_row(REQ_READ,   0,       0,     65540,      1, FREE_OWNER, 1'b0);
        add_row(REQ_WRITE,  3,       '1,    0,          1, '0, 1'b0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].req, directed_rows[k].file_id,
                         directed_rows[k].count, directed_rows[k].sector,
                         directed_rows[k].has_fixed, directed_rows[k].fixed_owner,
                         directed_rows[k].fixed_status);
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 150 || n == 300) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (owner_status_q.size() != 0) @(negedge i_clk);
            end
            id     = ($urandom_range(0, 6) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(0, 7)];
            count  = COUNT_W'($urandom);
            sector = SECTOR_W'($urandom);
            pick   = $urandom_range(0, 99);
            if (pick == 0) begin
                req = REQ_CLEAR;
            end else if (pick < 48) begin
                req  = REQ_WRITE;
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    count = 0;
                end else if (pick < 66) begin
                    count = COUNT_W'($urandom_range(1, 8));
                end else if (pick < 86) begin
                    count = COUNT_W'($urandom_range(9, 300));
                end else if (pick < 95) begin
                    count = COUNT_W'($urandom);
                end else begin
                    count = '1;
                end
            end else if (pick < 84) begin
                req  = REQ_READ;
                tail = '0;
                cur  = '0;
                for (k = 0; k < ext_used; k++) begin
                    if (ext_last[cur] == UNBOUNDED) begin
                        tail = ext_first[cur];
                    end
                    cur = ext_link[cur];
                end
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    sector = SECTOR_W'($urandom_range(0, tail + 2));
                end else if (pick < 80) begin
                    sector = SECTOR_W'($urandom_range(0, 20));
                end else if (pick < 97) begin
                    sector = SECTOR_W'($urandom);
                end else begin
                    sector = sector_max;
                end
            end else begin
                req = REQ_DELETE;
            end
            send_request(req, id, count, sector, 0, '0, 1'b0);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owner_status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (owner_status_q.size() != 0) begin
            report_mismatch("results never delivered", '0, owner_status_q.size());
        end

        $display("Run covered %0d writes, %0d reads, %0d deletes and %0d clears in %0d cycles.",
                 req_seen[REQ_WRITE], req_seen[REQ_READ], req_seen[REQ_DELETE],
                 req_seen[REQ_CLEAR], cycle_count);
        $display("Peak extent count %0d, %0d full-table writes, %0d results, %0d mismatches.",
                 peak_extents, full_count, result_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("first_fit_extent_sector_allocator test passed");
        end else begin
            $display("first_fit_extent_sector_allocator test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ffea_pkg.sv
sv/ffea_mem.sv
sv/ffea_ctrl.sv
sv/first_fit_extent_sector_allocator.sv
tb/sv/tb_first_fit_extent_sector_allocator.sv
